### hdl/q8bsd_pkg.sv
// Package for the block-scaled int8 dot product: lane constants, helper types shared by the
// lane and float modules, and fp32 functions used by the float module. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package q8bsd_pkg;

  localparam int unsigned Lanes     = 8;
  localparam int unsigned LaneBits  = 8;
  localparam int unsigned SumBits   = 32;
  localparam logic [31:0] CanonNan  = 32'h7FC00000;
  localparam logic [31:0] PosZero   = 32'h00000000;

  // Float pipeline states
  typedef enum logic [2:0] {
    FS_IDLE,
    FS_MUL1,
    FS_CVT,
    FS_MUL2,
    FS_ADD,
    FS_DONE
  } fstate_t;

  // Lane block to float unit hand-off
  typedef struct packed {
    logic        go;
    logic        row_end;
    logic [31:0] sum;
    logic [31:0] wscale;
    logic [31:0] ascale;
  } blk_req_t;

  // Round-to-nearest-even product of two binary32 values.
  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic        s;
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic signed [10:0] ex;
    logic [47:0] p;
    logic [49:0] w;   // p with two extra low bits for sticky
    logic        st;
    logic [9:0]  sh;
    logic [24:0] m;
    logic        g, r;
    logic [25:0] mr;
    int          i;
    logic [5:0]  lz;
    logic        fnd;
    begin
      s  = a[31] ^ b[31];
      ea = a[30:23];
      eb = b[30:23];
      fmul = {s, 31'd0};
      if ((ea == 8'hFF && a[22:0] != 0) || (eb == 8'hFF && b[22:0] != 0)) begin
        fmul = CanonNan;
      end else if (ea == 8'hFF || eb == 8'hFF) begin
        if ((ea == 8'h00 && a[22:0] == 0) || (eb == 8'h00 && b[22:0] == 0))
          fmul = CanonNan;
        else
          fmul = {s, 8'hFF, 23'd0};
      end else if ((ea == 8'h00 && a[22:0] == 0) || (eb == 8'h00 && b[22:0] == 0)) begin
        fmul = {s, 31'd0};
      end else begin
        ma = {(ea != 0), a[22:0]};
        mb = {(eb != 0), b[22:0]};
        ex = $signed({3'd0, ((ea == 0) ? 8'd1 : ea)})
           + $signed({3'd0, ((eb == 0) ? 8'd1 : eb)}) - 11'sd127;
        p  = ma * mb;   // value = p * 2^(ex-127-46)
        // normalise: leading one to bit 47
        lz  = 6'd0;
        fnd = 1'b0;
        for (i = 47; i >= 0; i--) begin
          if (!fnd && p[i]) begin
            fnd = 1'b1;
            lz  = 6'(47 - i);
          end
        end
        p  = p << lz;
        ex = ex + 11'sd1 - $signed({5'd0, lz});
        // subnormal handling
        st = 1'b0;
        if (ex < 11'sd1) begin
          sh = 10'(11'sd1 - ex);
          if (sh > 10'd49) sh = 10'd49;
          w  = {p, 2'b00};
          for (i = 0; i < 50; i++)
            if (i < int'(sh)) st = st | w[i];
          w  = w >> sh;
          p  = w[49:2];
          st = st | w[1] | w[0];
          ex = 11'sd0;
        end
        m  = {1'b0, p[47:24]};
        g  = p[23];
        r  = (|p[22:0]) | st;
        mr = {1'b0, m} + {25'd0, (g & (r | m[0]))};
        if (ex == 11'sd0) begin
          // subnormal result; carry into bit 23 makes it normal
          fmul = {s, 7'd0, mr[23], mr[22:0]};
        end else begin
          if (mr[24]) begin
            mr = mr >> 1;
            ex = ex + 11'sd1;
          end
          if (ex >= 11'sd255) fmul = {s, 8'hFF, 23'd0};
          else                fmul = {s, ex[7:0], mr[22:0]};
        end
      end
    end
  endfunction

  // Round-to-nearest-even conversion of a two's complement word to binary32.
  function automatic logic [31:0] i2f(input logic [31:0] v);
    logic        s;
    logic [31:0] mag;
    logic [4:0]  msb;
    logic [31:0] nm;
    logic [24:0] m;
    logic        g, r;
    logic [7:0]  e;
    int          i;
    begin
      s   = v[31];
      mag = s ? (~v + 32'd1) : v;
      msb = 5'd0;
      for (i = 0; i < 32; i++)
        if (mag[i]) msb = 5'(i);
      if (mag == 32'd0) begin
        i2f = PosZero;
      end else begin
        nm = mag << (5'd31 - msb);
        m  = {1'b0, nm[31:8]};
        g  = nm[7];
        r  = |nm[6:0];
        m  = m + {24'd0, (g & (r | m[0]))};
        e  = 8'd127 + {3'd0, msb};
        if (m[24]) begin
          m = m >> 1;
          e = e + 8'd1;
        end
        i2f = {s, e, m[22:0]};
      end
    end
  endfunction

  // Round-to-nearest-even sum of two binary32 values; NaN comes out canonical.
  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    logic [7:0]  ea, eb, eg, el;
    logic [26:0] mg, ml;   // hidden bit, 23 frac, guard, round, sticky
    logic        sg, sl, st;
    logic [7:0]  d;
    logic [27:0] sm;
    logic [9:0]  ex;
    logic [4:0]  lz;
    logic        fnd;
    logic [24:0] m;
    logic        g, r;
    int          i;
    begin
      ea = a[30:23];
      eb = b[30:23];
      fadd = PosZero;
      if ((ea == 8'hFF && a[22:0] != 0) || (eb == 8'hFF && b[22:0] != 0)) begin
        fadd = CanonNan;
      end else if (ea == 8'hFF && eb == 8'hFF) begin
        fadd = (a[31] == b[31]) ? a : CanonNan;
      end else if (ea == 8'hFF) begin
        fadd = a;
      end else if (eb == 8'hFF) begin
        fadd = b;
      end else begin
        if (a[30:0] >= b[30:0]) begin
          sg = a[31]; sl = b[31];
          eg = (ea == 0) ? 8'd1 : ea; el = (eb == 0) ? 8'd1 : eb;
          mg = {(ea != 0), a[22:0], 3'b000}; ml = {(eb != 0), b[22:0], 3'b000};
        end else begin
          sg = b[31]; sl = a[31];
          eg = (eb == 0) ? 8'd1 : eb; el = (ea == 0) ? 8'd1 : ea;
          mg = {(eb != 0), b[22:0], 3'b000}; ml = {(ea != 0), a[22:0], 3'b000};
        end
        d  = eg - el;
        st = 1'b0;
        if (d > 8'd26) begin
          st = |ml;
          ml = 27'd0;
        end else begin
          for (i = 0; i < 27; i++)
            if (i < int'(d)) st = st | ml[i];
          ml = ml >> d;
        end
        ml[0] = ml[0] | st;
        if (sg == sl) sm = {1'b0, mg} + {1'b0, ml};
        else          sm = {1'b0, mg} - {1'b0, ml};
        if (sm == 28'd0) begin
          fadd = (a[31] & b[31]) ? 32'h80000000 : PosZero;
        end else begin
          ex = {2'd0, eg};
          if (sm[27]) begin
            sm = {1'b0, sm[27:2], sm[1] | sm[0]};
            ex = ex + 10'd1;
          end else begin
            lz  = 5'd0;
            fnd = 1'b0;
            for (i = 26; i >= 0; i--) begin
              if (!fnd && sm[i]) begin
                fnd = 1'b1;
                lz  = 5'(26 - i);
              end
            end
            if ({5'd0, lz} >= ex) lz = 5'(ex - 10'd1);  // stop at subnormal range
            sm = sm << lz;
            ex = ex - {5'd0, lz};
          end
          m = {1'b0, sm[26:3]};
          g = sm[2];
          r = sm[1] | sm[0];
          m = m + {24'd0, (g & (r | m[0]))};
          if (m[24]) begin
            m  = m >> 1;
            ex = ex + 10'd1;
          end
          if (ex >= 10'd255)       fadd = {sg, 8'hFF, 23'd0};
          else if (ex == 10'd1 && !m[23]) fadd = {sg, 8'd0, m[22:0]};
          else                     fadd = {sg, ex[7:0], m[22:0]};
        end
      end
    end
  endfunction

endpackage
`default_nettype wire

### hdl/q8bsd_lanes.sv
// Eight int8 multiply lanes, a combinational adder tree and the block sum register.
// Depends on q8bsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module q8bsd_lanes (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        take,
  input  wire logic [63:0]                 weight_lanes,
  input  wire logic [63:0]                 act_lanes,
  input  wire logic [31:0]                 weight_scale,
  input  wire logic [31:0]                 act_scale,
  input  wire logic                        block_end,
  input  wire logic                        row_end,
  output q8bsd_pkg::blk_req_t              req
);

  logic signed [15:0] prod [q8bsd_pkg::Lanes];
  logic               s1_vld, s1_blk, s1_row;
  logic [31:0]        s1_ws, s1_as;
  logic signed [18:0] lane_sum;
  logic [31:0]        block_sum;
  logic [31:0]        sum_next;

  // Stage 1: one product per lane
  always_ff @(posedge clk) begin
    for (int i = 0; i < q8bsd_pkg::Lanes; i++) begin
      prod[i] <= $signed(weight_lanes[i*8 +: 8]) * $signed(act_lanes[i*8 +: 8]);
    end
    s1_blk <= block_end | row_end;
    s1_row <= row_end;
    s1_ws  <= weight_scale;
    s1_as  <= act_scale;
  end

  always_ff @(posedge clk) begin
    if (rst) s1_vld <= 1'b0;
    else     s1_vld <= take;
  end

  // Merge the lanes into the block sum
  always_comb begin
    lane_sum = '0;
    for (int i = 0; i < q8bsd_pkg::Lanes; i++) begin
      lane_sum = lane_sum + 19'(prod[i]);
    end
    sum_next = block_sum + 32'(lane_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_sum <= '0;
      req.go    <= 1'b0;
    end else begin
      req.go <= s1_vld & s1_blk;
      if (s1_vld) block_sum <= s1_blk ? 32'd0 : sum_next;
    end
    if (s1_vld & s1_blk) begin
      req.sum     <= sum_next;
      req.row_end <= s1_row;
      req.wscale  <= s1_ws;
      req.ascale  <= s1_as;
    end
  end

endmodule
`default_nettype wire

### hdl/q8bsd_float.sv
// Sequenced fp32 scale product, sum conversion, term product and row accumulation.
// Depends on q8bsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module q8bsd_float (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire q8bsd_pkg::blk_req_t  req,
  output logic                      busy,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output logic [31:0]               res_data
);

  q8bsd_pkg::fstate_t state, state_next;
  logic [31:0] scl, sf, term, row_acc, sum_r, ws, as_r;
  logic        row_r;

  always_ff @(posedge clk) begin
    if (rst) state <= q8bsd_pkg::FS_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    busy       = (state != q8bsd_pkg::FS_IDLE);
    res_valid  = (state == q8bsd_pkg::FS_DONE);
    case (state)
      q8bsd_pkg::FS_IDLE: if (req.go) state_next = q8bsd_pkg::FS_MUL1;
      q8bsd_pkg::FS_MUL1: state_next = q8bsd_pkg::FS_CVT;
      q8bsd_pkg::FS_CVT:  state_next = q8bsd_pkg::FS_MUL2;
      q8bsd_pkg::FS_MUL2: state_next = q8bsd_pkg::FS_ADD;
      q8bsd_pkg::FS_ADD:  state_next = row_r ? q8bsd_pkg::FS_DONE : q8bsd_pkg::FS_IDLE;
      q8bsd_pkg::FS_DONE: if (res_ready) state_next = q8bsd_pkg::FS_IDLE;
      default:            state_next = q8bsd_pkg::FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == q8bsd_pkg::FS_IDLE && req.go) begin
      sum_r <= req.sum;
      ws    <= req.wscale;
      as_r  <= req.ascale;
      row_r <= req.row_end;
    end
    if (state == q8bsd_pkg::FS_MUL1) scl  <= q8bsd_pkg::fmul(ws, as_r);
    if (state == q8bsd_pkg::FS_CVT)  sf   <= q8bsd_pkg::i2f(sum_r);
    if (state == q8bsd_pkg::FS_MUL2) term <= q8bsd_pkg::fmul(scl, sf);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_acc <= q8bsd_pkg::PosZero;
    end else if (state == q8bsd_pkg::FS_ADD) begin
      row_acc <= q8bsd_pkg::fadd(row_acc, term);
    end else if (state == q8bsd_pkg::FS_DONE && res_ready) begin
      row_acc <= q8bsd_pkg::PosZero;
    end
  end

  assign res_data = row_acc;

`ifndef SYNTHESIS
  a_go_idle: assert property (@(posedge clk) disable iff (rst)
    req.go |-> state == q8bsd_pkg::FS_IDLE) else $error("block request while float busy");
  a_done_row: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> row_r) else $error("result without row end");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready) |=> row_acc == q8bsd_pkg::PosZero)
    else $error("accumulator not cleared");
`endif

endmodule
`default_nettype wire

### hdl/q8_block_scaled_dot_product_top.sv
// Block-scaled int8 dot product, top level: ties the lane array to the float unit.
// Depends on q8bsd_pkg, q8bsd_lanes and q8bsd_float.
`timescale 1ns / 1ps
`default_nettype none
// Items without a block end are taken one per cycle unless an earlier block end still
// holds the input. An item with a block end (or row end) holds the input while it passes
// two lane stages (products, then adder tree into the block sum) and four steps of the
// shared fp32 unit (scale product, sum conversion, term product, accumulate), one per
// cycle. A row end waits further until row_value is taken. Row value NaNs are canonical.
module q8_block_scaled_dot_product_top (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // tdata: weight_lanes[63:0], act_lanes[127:64], weight_scale[159:128],
  //        act_scale[191:160]
  input  wire logic [191:0] s_tdata,
  // tuser: block_end
  input  wire logic         s_tuser,
  // tlast: row_end
  input  wire logic         s_tlast,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // tdata: row_value
  output logic [31:0]       m_tdata
);

  q8bsd_pkg::blk_req_t req;
  logic take, fbusy, s1, s2;

  // Hold the input while a block end drains through the lanes and the float unit
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= 1'b0;
      s2 <= 1'b0;
    end else begin
      s1 <= take & (s_tuser | s_tlast);
      s2 <= s1;
    end
  end

  assign s_tready = ~(s1 | s2 | fbusy);
  assign take     = s_tvalid & s_tready;

  q8bsd_lanes u_lanes (
    .clk,
    .rst,
    .take,
    .weight_lanes (s_tdata[63:0]),
    .act_lanes    (s_tdata[127:64]),
    .weight_scale (s_tdata[159:128]),
    .act_scale    (s_tdata[191:160]),
    .block_end    (s_tuser),
    .row_end      (s_tlast),
    .req
  );

  q8bsd_float u_float (
    .clk,
    .rst,
    .req,
    .busy      (fbusy),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res_data  (m_tdata)
  );

endmodule
`default_nettype wire
